[rtl/ssd_pkg.sv]
// Shared constants, codes and controller interface types for the sidechain ducker.
package ssd_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEF_FRAC_BITS  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ATTACK_COEF  = 2'd0,
      CSR_RELEASE_COEF = 2'd1,
      CSR_DUCK_DEPTH   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_ENVELOPE = 2'd0,
      MUL_DEPTH    = 2'd1,
      MUL_LEFT     = 2'd2,
      MUL_RIGHT    = 2'd3
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        env_we;
      logic        gain_we;
      logic        left_we;
      logic        out_we;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_sts_type;

endpackage

[rtl/ssd_req_if.sv]
// Stereo frame input channel: dry and wet samples with valid/ready.
interface ssd_req_if #(
   parameter int SAMPLE_WIDTH = ssd_pkg::SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] dry_left;
   logic signed [SAMPLE_WIDTH-1:0] dry_right;
   logic signed [SAMPLE_WIDTH-1:0] wet_left;
   logic signed [SAMPLE_WIDTH-1:0] wet_right;

   modport source (output valid, output dry_left, output dry_right,
                   output wet_left, output wet_right, input ready);
   modport sink   (input valid, input dry_left, input dry_right,
                   input wet_left, input wet_right, output ready);
endinterface

[rtl/ssd_rsp_if.sv]
// Ducked stereo output channel with valid/ready.
interface ssd_rsp_if #(
   parameter int SAMPLE_WIDTH = ssd_pkg::SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] out_left;
   logic signed [SAMPLE_WIDTH-1:0] out_right;

   modport source (output valid, output out_left, output out_right, input ready);
   modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

[rtl/ssd_csr_if.sv]
// Configuration write channel: register index and data with valid/ready.
interface ssd_csr_if #(
   parameter int COEF_FRAC_BITS = ssd_pkg::COEF_FRAC_BITS
);
   logic                                valid;
   logic                                ready;
   logic [ssd_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [COEF_FRAC_BITS:0]             data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/stereo_sidechain_ducker_core.sv]
// Top level of the stereo sidechain ducker: ties channels, registers, controller and datapath.
//
// Each input beat carries one stereo frame. The larger dry magnitude, times six and
// saturated at full scale, drives a one-pole envelope follower (attack coefficient on a
// rise, release otherwise); the wet pair is scaled by 1 - envelope * duck_depth. One
// frame is processed at a time: each frame is loaded, makes four passes through the
// single shared multiplier (envelope step, depth, left, right) and is written back.
// A finished result sits in an output register, so the next frame is accepted while it
// waits; a new result waits only if the previous one has still not been taken.
module stereo_sidechain_ducker_core #(
   parameter int SAMPLE_WIDTH   = ssd_pkg::SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = ssd_pkg::COEF_FRAC_BITS
) (
   input logic       clock,
   input logic       reset,
   ssd_req_if.sink   req_bus,
   ssd_rsp_if.source rsp_bus,
   ssd_csr_if.sink   csr_bus
);
   ssd_pkg::ctl_cmd_type    cmd;
   ssd_pkg::ctl_sts_type    sts;
   logic [COEF_FRAC_BITS:0] attack_coef;
   logic [COEF_FRAC_BITS:0] release_coef;
   logic [COEF_FRAC_BITS:0] duck_depth;

   ssd_csr_regs #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_bus.valid),
      .csr_ready    (csr_bus.ready),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .attack_coef  (attack_coef),
      .release_coef (release_coef),
      .duck_depth   (duck_depth)
   );

   ssd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ssd_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .dry_left     (req_bus.dry_left),
      .dry_right    (req_bus.dry_right),
      .wet_left     (req_bus.wet_left),
      .wet_right    (req_bus.wet_right),
      .attack_coef  (attack_coef),
      .release_coef (release_coef),
      .duck_depth   (duck_depth),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .out_left     (rsp_bus.out_left),
      .out_right    (rsp_bus.out_right)
   );
endmodule

[rtl/ssd_csr_regs.sv]
// Configuration registers: attack, release and depth, saturated to one on write.
module ssd_csr_regs #(
   parameter int COEF_FRAC_BITS = ssd_pkg::COEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_FRAC_BITS:0]             csr_data,
   output logic [COEF_FRAC_BITS:0]             attack_coef,
   output logic [COEF_FRAC_BITS:0]             release_coef,
   output logic [COEF_FRAC_BITS:0]             duck_depth
);
   localparam logic [COEF_FRAC_BITS:0] ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

   logic [COEF_FRAC_BITS:0] attack_ff;
   logic [COEF_FRAC_BITS:0] release_ff;
   logic [COEF_FRAC_BITS:0] depth_ff;
   logic [COEF_FRAC_BITS:0] data_sat;

   assign csr_ready = 1'b1;
   assign data_sat  = (csr_data > ONE) ? ONE : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= ONE;
         release_ff <= ONE;
         depth_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (ssd_pkg::csr_index_type'(csr_index))
            ssd_pkg::CSR_ATTACK_COEF:  attack_ff  <= data_sat;
            ssd_pkg::CSR_RELEASE_COEF: release_ff <= data_sat;
            ssd_pkg::CSR_DUCK_DEPTH:   depth_ff   <= data_sat;
            default: ;
         endcase
      end
   end

   assign attack_coef  = attack_ff;
   assign release_coef = release_ff;
   assign duck_depth   = depth_ff;
endmodule

[rtl/ssd_datapath.sv]
// Datapath: peak detector, shared multiplier, envelope and gain registers, output beat.
module ssd_datapath #(
   parameter int SAMPLE_WIDTH   = ssd_pkg::SAMPLE_WIDTH,
   parameter int COEF_FRAC_BITS = ssd_pkg::COEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ssd_pkg::ctl_cmd_type           cmd,
   output ssd_pkg::ctl_sts_type           sts,
   input  logic signed [SAMPLE_WIDTH-1:0] dry_left,
   input  logic signed [SAMPLE_WIDTH-1:0] dry_right,
   input  logic signed [SAMPLE_WIDTH-1:0] wet_left,
   input  logic signed [SAMPLE_WIDTH-1:0] wet_right,
   input  logic [COEF_FRAC_BITS:0]        attack_coef,
   input  logic [COEF_FRAC_BITS:0]        release_coef,
   input  logic [COEF_FRAC_BITS:0]        duck_depth,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] out_left,
   output logic signed [SAMPLE_WIDTH-1:0] out_right
);
   localparam int RW = COEF_FRAC_BITS + 1;
   localparam int DW = COEF_FRAC_BITS + 2;
   localparam int ES = COEF_FRAC_BITS + 3;
   localparam int BW = SAMPLE_WIDTH + 3;
   localparam int MW = (SAMPLE_WIDTH > DW) ? SAMPLE_WIDTH : DW;
   localparam int PW = MW + DW;
   localparam logic [RW-1:0] ONE        = {1'b1, {COEF_FRAC_BITS{1'b0}}};
   localparam logic [BW-1:0] FULL_SCALE = BW'(1) << (SAMPLE_WIDTH - 1);

   logic [SAMPLE_WIDTH-1:0]                mag_l;
   logic [SAMPLE_WIDTH-1:0]                mag_r;
   logic [SAMPLE_WIDTH-1:0]                peak;
   logic [BW-1:0]                          boosted_full;
   logic [SAMPLE_WIDTH-1:0]                boosted;
   logic [SAMPLE_WIDTH+COEF_FRAC_BITS-1:0] scaled;

   logic [RW-1:0]                  target_ff;
   logic signed [SAMPLE_WIDTH-1:0] wet_l_ff;
   logic signed [SAMPLE_WIDTH-1:0] wet_r_ff;
   logic [RW-1:0]                  env_ff;
   logic [RW-1:0]                  gain_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [SAMPLE_WIDTH-1:0] left_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_left_ff;
   logic signed [SAMPLE_WIDTH-1:0] out_right_ff;
   logic                           rsp_valid_ff;

   logic signed [DW-1:0] diff;
   logic [RW-1:0]        coef_sel;
   logic signed [PW-1:0] prod_shift;
   logic signed [ES-1:0] env_sum;
   logic [RW-1:0]        env_in;
   logic [RW-1:0]        ctl;
   logic [RW-1:0]        gain_in;
   logic signed [MW-1:0] mul_a;
   logic signed [DW-1:0] mul_b;

   // peak detector, times six, saturate at full scale, rescale to Q1.COEF_FRAC_BITS
   always_comb begin
      mag_l        = dry_left[SAMPLE_WIDTH-1]  ? (~dry_left  + SAMPLE_WIDTH'(1)) : dry_left;
      mag_r        = dry_right[SAMPLE_WIDTH-1] ? (~dry_right + SAMPLE_WIDTH'(1)) : dry_right;
      peak         = (mag_l > mag_r) ? mag_l : mag_r;
      boosted_full = {1'b0, peak, 2'b00} + {2'b00, peak, 1'b0};
      boosted      = (boosted_full > FULL_SCALE) ? FULL_SCALE[SAMPLE_WIDTH-1:0]
                                                 : boosted_full[SAMPLE_WIDTH-1:0];
      scaled       = {boosted, {COEF_FRAC_BITS{1'b0}}};
   end

   always_comb begin
      diff       = $signed({1'b0, target_ff}) - $signed({1'b0, env_ff});
      coef_sel   = (target_ff > env_ff) ? attack_coef : release_coef;
      prod_shift = prod_ff >>> COEF_FRAC_BITS;
      env_sum    = $signed({2'b00, env_ff}) + $signed(prod_shift[DW:0]);
      if (env_sum[ES-1]) begin
         env_in = '0;
      end else if (env_sum > $signed({2'b00, ONE})) begin
         env_in = ONE;
      end else begin
         env_in = env_sum[RW-1:0];
      end
      ctl     = (prod_ff[COEF_FRAC_BITS +: RW] > ONE) ? ONE : prod_ff[COEF_FRAC_BITS +: RW];
      gain_in = ONE - ctl;
   end

   always_comb begin
      case (cmd.mul_sel)
         ssd_pkg::MUL_ENVELOPE: begin
            mul_a = MW'(diff);
            mul_b = $signed({1'b0, coef_sel});
         end
         ssd_pkg::MUL_DEPTH: begin
            mul_a = $signed(MW'({1'b0, env_in}));
            mul_b = $signed({1'b0, duck_depth});
         end
         ssd_pkg::MUL_LEFT: begin
            mul_a = MW'(wet_l_ff);
            mul_b = $signed({1'b0, gain_in});
         end
         ssd_pkg::MUL_RIGHT: begin
            mul_a = MW'(wet_r_ff);
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= scaled[SAMPLE_WIDTH-1 +: RW];
         wet_l_ff  <= wet_left;
         wet_r_ff  <= wet_right;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.gain_we) begin
         gain_ff <= gain_in;
      end
      if (cmd.left_we) begin
         left_ff <= prod_ff[COEF_FRAC_BITS +: SAMPLE_WIDTH];
      end
      if (cmd.out_we) begin
         out_left_ff  <= left_ff;
         out_right_ff <= prod_ff[COEF_FRAC_BITS +: SAMPLE_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.env_we) begin
            env_ff <= env_in;
         end
         if (cmd.out_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign out_left     = out_left_ff;
   assign out_right    = out_right_ff;

   a_env_bound: assert property (@(posedge clock) disable iff (reset)
      env_ff <= ONE) else $error("envelope above one");

   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_en && (cmd.mul_sel == ssd_pkg::MUL_RIGHT) |-> gain_ff <= ONE)
      else $error("gain above one");

   a_out_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |=> rsp_valid_ff) else $error("result beat lost");
endmodule

[rtl/ssd_controller.sv]
// Controller: sequences load, envelope, depth and per-channel multiplies for each frame.
module ssd_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output ssd_pkg::ctl_cmd_type cmd,
   input  ssd_pkg::ctl_sts_type sts
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_ENV,
      S_DEPTH,
      S_LEFT,
      S_RIGHT,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= S_ENV;
                  req_ready_ff <= 1'b0;
               end
            end
            S_ENV:   state_ff <= S_DEPTH;
            S_DEPTH: state_ff <= S_LEFT;
            S_LEFT:  state_ff <= S_RIGHT;
            S_RIGHT: state_ff <= S_DONE;
            S_DONE: begin
               if (sts.out_free) begin
                  state_ff     <= S_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = ssd_pkg::MUL_ENVELOPE;
      case (state_ff)
         S_IDLE: cmd.load = req_valid && req_ready_ff;
         S_ENV: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ssd_pkg::MUL_ENVELOPE;
         end
         S_DEPTH: begin
            cmd.env_we  = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ssd_pkg::MUL_DEPTH;
         end
         S_LEFT: begin
            cmd.gain_we = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ssd_pkg::MUL_LEFT;
         end
         S_RIGHT: begin
            cmd.left_we = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ssd_pkg::MUL_RIGHT;
         end
         S_DONE: cmd.out_we = sts.out_free;
         default: ;
      endcase
   end

   assign req_ready = req_ready_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_ENV) else $error("frame not started");

   a_done_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.out_we |=> req_ready_ff) else $error("input not reopened");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.env_we, cmd.gain_we, cmd.left_we, cmd.out_we}))
      else $error("overlapping datapath writes");
endmodule
